@@ src/rolling_moving_average_top_defines.svh @@
// ----------------------------------------------------------------------------
// rolling_moving_average_top_defines
// Assertion macros shared by the moving average checker.
// ----------------------------------------------------------------------------
`ifndef ROLLING_MOVING_AVERAGE_TOP_DEFINES_SVH
`define ROLLING_MOVING_AVERAGE_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define RMA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rolling moving average: assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define RMA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rolling moving average: assertion failed");

`endif

@@ src/rma_pkg.sv @@
// ----------------------------------------------------------------------------
// rma_pkg
// Shared widths, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rma_pkg;

  localparam int MAX_WINDOW_DEF = 256;
  localparam int DEFAULT_WINDOW = 20;

  localparam int PRICE_W   = 32;
  localparam int AVG_W     = 40;
  localparam int FRAC_W    = 8;
  localparam int CFG_LEN_W = 9;

  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LEN = '0;

  typedef struct packed {
    logic capture;
    logic delta;
    logic accum;
    logic load_div;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic full;
  } status_t;

endpackage

@@ src/rma_ctrl.sv @@
// ----------------------------------------------------------------------------
// rma_ctrl
// Sequencer: capture, ring update, serial divide and result hand-off.
// ----------------------------------------------------------------------------
module rma_ctrl #(
  parameter int MAX_WINDOW = rma_pkg::MAX_WINDOW_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output rma_pkg::cmd_t    cmd,
  input  rma_pkg::status_t st
);
  import rma_pkg::*;

  localparam int IDX_W  = $clog2(MAX_WINDOW);
  localparam int DIV_W  = PRICE_W + IDX_W + FRAC_W;
  localparam int STEP_W = $clog2(DIV_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DELTA,
    S_ACCUM,
    S_LOAD,
    S_DIV,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  logic              out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.capture  = in_valid && (state_r == S_IDLE);
    cmd.delta    = (state_r == S_DELTA);
    cmd.accum    = (state_r == S_ACCUM);
    cmd.load_div = (state_r == S_LOAD);
    cmd.div_step = (state_r == S_DIV);
    cmd.load_out = (state_r == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_DELTA;
          end
        end
        S_DELTA: state_r <= S_ACCUM;
        S_ACCUM: state_r <= S_LOAD;
        S_LOAD: begin
          step_r  <= '0;
          state_r <= st.full ? S_DIV : S_DONE;
        end
        S_DIV: begin
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(DIV_W - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/rma_dp.sv @@
// ----------------------------------------------------------------------------
// rma_dp
// Price ring, running sum, window counters, serial divider, result register.
// ----------------------------------------------------------------------------
module rma_dp #(
  parameter int MAX_WINDOW = rma_pkg::MAX_WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rma_pkg::cmd_t                        cmd,
  output rma_pkg::status_t                     st,
  input  logic                                 cfg_we,
  input  logic        [rma_pkg::CFG_LEN_W-1:0] cfg_wdata,
  output logic        [rma_pkg::CFG_LEN_W-1:0] window_len,
  input  logic signed [rma_pkg::PRICE_W-1:0]   in_close_price,
  output logic signed [rma_pkg::AVG_W-1:0]     out_average,
  output logic                                 out_window_full
);
  import rma_pkg::*;

  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = PRICE_W + IDX_W;
  localparam int DIV_W = SUM_W + FRAC_W;
  localparam int REM_W = CNT_W + 1;

  logic [PRICE_W-1:0] ring_mem [MAX_WINDOW];

  logic        [CFG_LEN_W-1:0] window_len_r;
  logic        [IDX_W-1:0]     write_slot_r;
  logic        [CNT_W-1:0]     seen_r;
  logic signed [SUM_W-1:0]     sum_r;
  logic                        full_r;

  logic signed [PRICE_W-1:0]   close_r;
  logic        [IDX_W-1:0]     slot_r;
  logic signed [PRICE_W-1:0]   old_r;
  logic signed [PRICE_W:0]     delta_r;
  logic        [DIV_W-1:0]     quo_r;
  logic        [REM_W-1:0]     rem_r;
  logic                        neg_r;
  logic signed [AVG_W-1:0]     avg_r;
  logic                        avg_full_r;

  logic [31:0]       len_wide;
  logic [CNT_W-1:0]  eff_len;
  logic [IDX_W-1:0]  rd_slot;
  logic [CNT_W-1:0]  slot_inc;
  logic [IDX_W-1:0]  slot_nxt;
  logic [CNT_W-1:0]  seen_nxt;
  logic signed [SUM_W-1:0] sum_nxt;
  logic              ring_full;
  logic [DIV_W-1:0]  dividend;
  logic [DIV_W-1:0]  magnitude;
  logic [REM_W-1:0]  rem_sh;
  logic              rem_ge;
  logic [REM_W-1:0]  rem_nxt;
  logic [AVG_W-1:0]  quo_trim;

  always_comb begin
    len_wide = (window_len_r == '0) ? 32'(DEFAULT_WINDOW) : 32'(window_len_r);
    if (len_wide > 32'(MAX_WINDOW)) begin
      len_wide = 32'(MAX_WINDOW);
    end
    eff_len = len_wide[CNT_W-1:0];
  end

  assign ring_full = (seen_r >= eff_len);
  assign rd_slot   = (CNT_W'(write_slot_r) >= eff_len) ? '0 : write_slot_r;
  assign slot_inc  = CNT_W'(slot_r) + 1'b1;
  assign slot_nxt  = (slot_inc >= eff_len) ? '0 : slot_inc[IDX_W-1:0];
  assign seen_nxt  = ring_full ? seen_r : seen_r + 1'b1;
  assign sum_nxt   = sum_r + SUM_W'(delta_r);

  assign dividend  = {sum_r, {FRAC_W{1'b0}}};
  assign magnitude = sum_r[SUM_W-1] ? (~dividend + 1'b1) : dividend;

  assign rem_sh  = {rem_r[REM_W-2:0], quo_r[DIV_W-1]};
  assign rem_ge  = (rem_sh >= REM_W'(eff_len));
  assign rem_nxt = rem_ge ? (rem_sh - REM_W'(eff_len)) : rem_sh;

  assign quo_trim = quo_r[AVG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= CFG_LEN_W'(DEFAULT_WINDOW);
      write_slot_r <= '0;
      seen_r       <= '0;
      sum_r        <= '0;
      full_r       <= 1'b0;
    end else if (cfg_we) begin
      window_len_r <= cfg_wdata;
      write_slot_r <= '0;
      seen_r       <= '0;
      sum_r        <= '0;
      full_r       <= 1'b0;
    end else if (cmd.accum) begin
      write_slot_r <= slot_nxt;
      seen_r       <= seen_nxt;
      sum_r        <= sum_nxt;
      full_r       <= (seen_nxt >= eff_len);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      close_r <= in_close_price;
      slot_r  <= rd_slot;
      old_r   <= ring_mem[rd_slot];
    end
    if (cmd.delta) begin
      ring_mem[slot_r] <= close_r;
      delta_r <= ring_full ? ((PRICE_W+1)'(close_r) - (PRICE_W+1)'(old_r))
                           : (PRICE_W+1)'(close_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      quo_r <= magnitude;
      rem_r <= '0;
      neg_r <= sum_r[SUM_W-1];
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[DIV_W-2:0], rem_ge};
      rem_r <= rem_nxt;
    end
    if (cmd.load_out) begin
      avg_full_r <= full_r;
      if (full_r) begin
        avg_r <= neg_r ? -signed'(quo_trim) : signed'(quo_trim);
      end else begin
        avg_r <= AVG_W'(close_r) <<< FRAC_W;
      end
    end
  end

  assign st.full         = full_r;
  assign window_len      = window_len_r;
  assign out_average     = avg_r;
  assign out_window_full = avg_full_r;

endmodule

@@ src/rolling_moving_average_top.sv @@
// ----------------------------------------------------------------------------
// rolling_moving_average_top
// Simple moving average of signed close prices, 8 fraction bits out.
// ----------------------------------------------------------------------------
// One result beat per input beat. During warm-up the result is the close
// scaled by 256, loaded into the output register after the delta,
// accumulate and load steps. With a full window the result is sum*256/L,
// truncated toward zero, from a restoring divider that retires one
// quotient bit per cycle over a 32+log2(MAX_WINDOW)+8 bit dividend
// (MAX_WINDOW defaults to 256), loaded into the output register once the
// divide ends. One item is in flight at a time; the next beat is taken
// while the previous result still waits in the output register.
// Writing window_len (0 means 20, values above MAX_WINDOW saturate) restarts
// the warm-up; write it only while the block is idle.
// ----------------------------------------------------------------------------
module rolling_moving_average_top #(
  parameter int MAX_WINDOW = rma_pkg::MAX_WINDOW_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [rma_pkg::PRICE_W-1:0] in_close_price,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [rma_pkg::AVG_W-1:0]   out_average,
  output logic                               out_window_full,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic        [rma_pkg::ADDR_W-1:0]  paddr,
  input  logic        [rma_pkg::DATA_W-1:0]  pwdata,
  output logic        [rma_pkg::DATA_W-1:0]  prdata,
  output logic                               pready
);
  import rma_pkg::*;

  cmd_t                 cmd;
  status_t              st;
  logic                 cfg_we;
  logic [CFG_LEN_W-1:0] window_len;
  logic                 sel_len;

  assign sel_len = (paddr[ADDR_W-1:2] == REG_WINDOW_LEN);
  assign cfg_we  = psel && penable && pwrite && sel_len;
  assign prdata  = sel_len ? DATA_W'(window_len) : '0;
  assign pready  = 1'b1;

  rma_ctrl #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .st        (st)
  );

  rma_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .cfg_we          (cfg_we),
    .cfg_wdata       (pwdata[CFG_LEN_W-1:0]),
    .window_len      (window_len),
    .in_close_price  (in_close_price),
    .out_average     (out_average),
    .out_window_full (out_window_full)
  );

endmodule

@@ src/rma_checker.sv @@
// ----------------------------------------------------------------------------
// rma_checker
// Port-level checks for the moving average block, bound to the top level.
// ----------------------------------------------------------------------------
`include "rolling_moving_average_top_defines.svh"

module rma_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [rma_pkg::AVG_W-1:0]   out_average,
  input logic                               out_window_full,
  input logic                               psel,
  input logic                               penable,
  input logic                               pwrite,
  input logic        [rma_pkg::ADDR_W-1:0]  paddr,
  input logic        [rma_pkg::DATA_W-1:0]  pwdata,
  input logic        [rma_pkg::DATA_W-1:0]  prdata
);
  import rma_pkg::*;

  // stalled result beat holds
  `RMA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_average) && $stable(out_window_full))

  // one item in flight: busy right after an accepted beat
  `RMA_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // warm-up passthrough is an integer close, fraction bits clear
  `RMA_ASSERT_IMP(a_warmup_frac, out_valid && !out_window_full, out_average[FRAC_W-1:0] == '0)

  // window_len reads back what was written
  `RMA_ASSERT_NXT(a_cfg_readback, psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_WINDOW_LEN), (paddr[ADDR_W-1:2] != REG_WINDOW_LEN) || (prdata[CFG_LEN_W-1:0] == $past(pwdata[CFG_LEN_W-1:0])))

endmodule

bind rolling_moving_average_top rma_checker u_rma_checker (.*);
